// ----- design/bgpi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgpi_pkg
// Shared types and constants of the Bayer green plane interpolator.
// ----------------------------------------------------------------------------
package bgpi_pkg;

  // Geometry and sample size
  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int PIXEL_BITS  = 16;

  // Fixed field widths
  localparam int FIELD_BITS     = 16;
  localparam int DIM_BITS       = 13;
  localparam int CFG_DATA_BITS  = 13;
  localparam int CFG_INDEX_BITS = 3;

  // Derived widths
  localparam int SAMPLE_BITS = (PIXEL_BITS < FIELD_BITS) ? PIXEL_BITS : FIELD_BITS;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int ROW_BITS    = $clog2(MAX_HEIGHT + 1);
  localparam int CMP_BITS    = 16;

  // Register reset values
  localparam logic [1:0]          PATTERN_RESET = 2'd0;
  localparam logic [DIM_BITS-1:0] WIDTH_RESET   = DIM_BITS'(4096);
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET  = DIM_BITS'(4096);
  localparam logic                ENABLE_RESET  = 1'b1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PATTERN      = 3'd0,
    REG_FRAME_WIDTH  = 3'd1,
    REG_FRAME_HEIGHT = 3'd2,
    REG_ENABLE       = 3'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } command_t;

  typedef struct packed {
    command_t              command;
    logic [FIELD_BITS-1:0] pixel;
  } sample_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] green;
    logic                  frame_last;
  } result_t;

endpackage

// ----- design/bgpi_line_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgpi_line_ram
// Line store: one write port, two registered read ports, write-first on a
// read of the entry written in the same cycle.
// ----------------------------------------------------------------------------
module bgpi_line_ram #(
  parameter  int DEPTH     = 4096,
  parameter  int WIDTH     = 16,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr_a,
  input  logic [ADDR_BITS-1:0] raddr_b,
  output logic [WIDTH-1:0]     rdata_a,
  output logic [WIDTH-1:0]     rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and forward the new word to a read of the same entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= (we && (waddr == raddr_a)) ? wdata : mem[raddr_a];
    rdata_b <= (we && (waddr == raddr_b)) ? wdata : mem[raddr_b];
  end

endmodule

// ----- design/bgpi_out_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgpi_out_fifo
// Two-entry result buffer: a head register and a skid register.
// ----------------------------------------------------------------------------
module bgpi_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bgpi_pkg::result_t push_item,
  output logic              space,
  output logic              result_valid,
  input  logic              result_ready,
  output bgpi_pkg::result_t result
);

  logic [1:0]        count;
  logic [1:0]        count_next;
  bgpi_pkg::result_t head;
  bgpi_pkg::result_t skid;
  logic              pop;

  assign pop          = result_valid && result_ready;
  assign space        = (count != 2'd2);
  assign result_valid = (count != 2'd0);
  assign result       = head;

  // Track occupancy
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // Move payload: head takes the skid on a pop, new items fill behind
  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        head <= skid;
        if (push) begin
          skid <= push_item;
        end
      end else if (push) begin
        head <= push_item;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        head <= push_item;
      end else begin
        skid <= push_item;
      end
    end
  end

endmodule

// ----- design/bayer_green_plane_interpolator_core.sv -----
`timescale 1ns / 1ps
// Output: a result enters the output buffer at the edge that transfers the
//   sample causing it and is offered from the next cycle on.
// Throughput: one sample per clock; the line stores are read ahead at the
//   next raster position. sample_ready drops only when both output slots are full.
// Reset (rst, synchronous): clears counters and output buffer, restores the
//   register defaults; line stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// bayer_green_plane_interpolator_core
// Bilinear green plane from a raster Bayer stream with one row of lag, or a
// plain pass-through when disabled; two line stores in block memories.
// ----------------------------------------------------------------------------
module bayer_green_plane_interpolator_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  sample_valid,
  output logic                                  sample_ready,
  input  bgpi_pkg::sample_t                     sample,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output bgpi_pkg::result_t                     result,
  input  logic                                  cfg_we,
  input  logic [bgpi_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [bgpi_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int SB  = bgpi_pkg::SAMPLE_BITS;
  localparam int CB  = bgpi_pkg::COL_BITS;
  localparam int RB  = bgpi_pkg::ROW_BITS;
  localparam int DB  = bgpi_pkg::DIM_BITS;
  localparam int MB  = bgpi_pkg::CMP_BITS;

  // Configuration registers
  logic [1:0]    pattern;
  logic [DB-1:0] frame_width;
  logic [DB-1:0] frame_height;
  logic          enable;
  logic          cfg_hit;

  // Raster counters
  logic [CB-1:0] column_count, column_count_next;
  logic [RB-1:0] row_count, row_count_next;
  logic [CB-1:0] drain_count, drain_count_next;

  logic [DB-1:0] w_eff;
  logic [DB-1:0] h_eff;
  logic          draining, draining_next;
  logic          col_last, row_last, drain_last, pos_last;
  logic [CB-1:0] pos, pos_next, rd_pos;

  // Memory ports
  logic          center_we, upper_we;
  logic [SB-1:0] cen, right_raw, up_raw, left_raw;

  // Datapath
  logic          accept;
  logic          y_lsb, y_first, green_site;
  logic [SB-1:0] pix, up, down, left, right, interp, green_val;
  logic [SB+1:0] sum;
  logic          push;
  bgpi_pkg::result_t push_item;

  // Decode register writes
  assign cfg_hit = cfg_we && ((cfg_index == bgpi_pkg::REG_PATTERN) ||
                              (cfg_index == bgpi_pkg::REG_FRAME_WIDTH) ||
                              (cfg_index == bgpi_pkg::REG_FRAME_HEIGHT) ||
                              (cfg_index == bgpi_pkg::REG_ENABLE));

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern      <= bgpi_pkg::PATTERN_RESET;
      frame_width  <= bgpi_pkg::WIDTH_RESET;
      frame_height <= bgpi_pkg::HEIGHT_RESET;
      enable       <= bgpi_pkg::ENABLE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bgpi_pkg::REG_PATTERN:      pattern      <= cfg_data[1:0];
        bgpi_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[DB-1:0];
        bgpi_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[DB-1:0];
        bgpi_pkg::REG_ENABLE:       enable       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Limit geometry to the supported range
  always_comb begin
    if (frame_width == '0) begin
      w_eff = DB'(1);
    end else if (MB'(frame_width) > MB'(bgpi_pkg::MAX_WIDTH)) begin
      w_eff = DB'(bgpi_pkg::MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height == '0) begin
      h_eff = DB'(1);
    end else if (MB'(frame_height) > MB'(bgpi_pkg::MAX_HEIGHT)) begin
      h_eff = DB'(bgpi_pkg::MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  // Raster position flags
  assign draining   = (MB'(row_count) >= MB'(h_eff));
  assign col_last   = (MB'(column_count) + MB'(1) >= MB'(w_eff));
  assign drain_last = (MB'(drain_count) + MB'(1) >= MB'(w_eff));
  assign row_last   = (MB'(row_count) + MB'(1) >= MB'(h_eff));
  assign pos        = draining ? drain_count : column_count;
  assign pos_last   = draining ? drain_last : col_last;

  assign accept = sample_valid && sample_ready;
  assign pix    = sample.pixel[SB-1:0];

  // Cross neighbors; clamp at the frame edges
  assign y_lsb   = draining ? ~h_eff[0] : ~row_count[0];
  assign y_first = draining ? (h_eff == DB'(1)) : (row_count == RB'(1));
  assign green_site = pattern[1] ? ((pos[0] ^ y_lsb) == 1'b0) : ((pos[0] ^ y_lsb) == 1'b1);

  assign up     = y_first ? cen : up_raw;
  assign left   = (pos == '0) ? cen : left_raw;
  assign right  = pos_last ? cen : right_raw;
  assign down   = draining ? cen : pix;
  assign sum    = (SB+2)'(up) + (SB+2)'(down) + (SB+2)'(left) + (SB+2)'(right);
  assign interp = sum[SB+1:2];
  assign green_val = green_site ? cen : interp;

  // Sequence one transfer: counters, store writes, result push
  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    drain_count_next  = drain_count;
    center_we         = 1'b0;
    upper_we          = 1'b0;
    push              = 1'b0;
    push_item.green      = bgpi_pkg::FIELD_BITS'(green_val);
    push_item.frame_last = 1'b0;
    if (cfg_hit) begin
      column_count_next = '0;
      row_count_next    = '0;
      drain_count_next  = '0;
    end else if (accept) begin
      if (!enable) begin
        if (sample.command == bgpi_pkg::CMD_PIXEL) begin
          push                 = 1'b1;
          push_item.green      = bgpi_pkg::FIELD_BITS'(pix);
          push_item.frame_last = col_last && row_last;
          if (col_last && row_last) begin
            column_count_next = '0;
            row_count_next    = '0;
            drain_count_next  = '0;
          end else if (col_last) begin
            column_count_next = '0;
            row_count_next    = row_count + RB'(1);
          end else begin
            column_count_next = column_count + CB'(1);
          end
        end
      end else if (sample.command == bgpi_pkg::CMD_PIXEL) begin
        if (!draining) begin
          push      = (row_count != '0);
          center_we = 1'b1;
          upper_we  = 1'b1;
          if (col_last) begin
            column_count_next = '0;
            row_count_next    = row_count + RB'(1);
          end else begin
            column_count_next = column_count + CB'(1);
          end
        end
      end else if (draining) begin
        push                 = 1'b1;
        upper_we             = 1'b1;
        push_item.frame_last = drain_last;
        if (drain_last) begin
          column_count_next = '0;
          row_count_next    = '0;
          drain_count_next  = '0;
        end else begin
          drain_count_next = drain_count + CB'(1);
        end
      end
    end
  end

  // Read ahead at the position of the next transfer
  assign draining_next = (MB'(row_count_next) >= MB'(h_eff));
  assign pos_next      = draining_next ? drain_count_next : column_count_next;
  assign rd_pos        = rst ? '0 : pos_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      drain_count  <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      drain_count  <= drain_count_next;
    end
  end

  // Newest complete row
  bgpi_line_ram #(
    .DEPTH (bgpi_pkg::MAX_WIDTH),
    .WIDTH (SB)
  ) u_center_ram (
    .clk     (clk),
    .we      (center_we),
    .waddr   (pos),
    .wdata   (pix),
    .raddr_a (rd_pos),
    .raddr_b (rd_pos + CB'(1)),
    .rdata_a (cen),
    .rdata_b (right_raw)
  );

  // Row above, refreshed column by column behind the center store
  bgpi_line_ram #(
    .DEPTH (bgpi_pkg::MAX_WIDTH),
    .WIDTH (SB)
  ) u_upper_ram (
    .clk     (clk),
    .we      (upper_we),
    .waddr   (pos),
    .wdata   (cen),
    .raddr_a (rd_pos),
    .raddr_b (rd_pos - CB'(1)),
    .rdata_a (up_raw),
    .rdata_b (left_raw)
  );

  bgpi_out_fifo u_out_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_item    (push_item),
    .space        (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // A register write starts a new frame
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> (column_count == '0) && (row_count == '0) && (drain_count == '0))
    else $error("counters not cleared after register write");

  // Drain position only moves once all rows are in
  a_drain_phase: assert property (@(posedge clk) disable iff (rst)
    (drain_count != '0) |-> draining)
    else $error("drain count set outside the drain phase");

  // Column stays inside the row in use
  a_column_range: assert property (@(posedge clk) disable iff (rst)
    MB'(column_count) < MB'(w_eff))
    else $error("column count beyond frame width");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench of bayer_green_plane_interpolator_core
// Streams Bayer frames through the core over both valid/ready channels and
// checks every green result against an in-bench model of the line stores,
// the edge clamping and the drain sequence. Directed frames cover the corner
// cases, out-of-range geometries get a partial frame each, and randomized
// frames run under four mixes of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_WIDTH      = bgpi_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT     = bgpi_pkg::MAX_HEIGHT;
  localparam int FIELD_BITS     = bgpi_pkg::FIELD_BITS;
  localparam int DIM_BITS       = bgpi_pkg::DIM_BITS;
  localparam int CFG_INDEX_BITS = bgpi_pkg::CFG_INDEX_BITS;
  localparam int CFG_DATA_BITS  = bgpi_pkg::CFG_DATA_BITS;

  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 190;
  localparam int EDGE_ITEMS    = 40;

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      sample_valid = 1'b0;
  logic                      sample_ready;
  bgpi_pkg::sample_t         sample       = '0;
  logic                      result_valid;
  logic                      result_ready = 1'b0;
  bgpi_pkg::result_t         result;
  logic                      cfg_we       = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;

  // Shadow registers and line stores of the green model
  logic [1:0]            cfg_pattern;
  logic [DIM_BITS-1:0]   cfg_width;
  logic [DIM_BITS-1:0]   cfg_height;
  logic                  cfg_enable;
  logic [FIELD_BITS-1:0] line_above  [MAX_WIDTH];
  logic [FIELD_BITS-1:0] line_center [MAX_WIDTH];
  int                    col_pos;
  int                    row_pos;
  int                    drain_pos;

  bgpi_pkg::result_t expected_green[$];

  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int mismatches     = 0;
  int transfers_in   = 0;
  int used_items     = 0;
  int results_seen   = 0;
  int frame_ends     = 0;
  int drained_greens = 0;
  int passed_through = 0;
  int settings_used  = 0;
  int quiet_cycles   = 0;

  bayer_green_plane_interpolator_core uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Green model
  // --------------------------------------------------------------------------
  function automatic int clamp_dim(logic [DIM_BITS-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic logic is_green_site(int x, int y);
    logic odd;
    odd = x[0] ^ y[0];
    return (cfg_pattern >= 2) ? !odd : odd;
  endfunction

  // Cross average around (x, y); the lower neighbor comes from the caller
  function automatic logic [FIELD_BITS-1:0] cross_green(int x, int y, int w,
                                                        logic [FIELD_BITS-1:0] below);
    logic [FIELD_BITS-1:0] mid;
    logic [FIELD_BITS-1:0] above;
    logic [FIELD_BITS-1:0] left_px;
    logic [FIELD_BITS-1:0] right_px;
    logic [FIELD_BITS+1:0] total;
    mid      = line_center[x];
    above    = (y == 0) ? mid : line_above[x];
    left_px  = (x == 0) ? mid : line_above[x-1];
    right_px = (x + 1 < w) ? line_center[x+1] : mid;
    if (is_green_site(x, y)) return mid;
    total = (FIELD_BITS+2)'(above) + (FIELD_BITS+2)'(below) +
            (FIELD_BITS+2)'(left_px) + (FIELD_BITS+2)'(right_px);
    return total[FIELD_BITS+1:2];
  endfunction

  task automatic clear_position();
    col_pos   = 0;
    row_pos   = 0;
    drain_pos = 0;
  endtask

  task automatic reset_model();
    cfg_pattern = bgpi_pkg::PATTERN_RESET;
    cfg_width   = bgpi_pkg::WIDTH_RESET;
    cfg_height  = bgpi_pkg::HEIGHT_RESET;
    cfg_enable  = bgpi_pkg::ENABLE_RESET;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_above[i]  = '0;
      line_center[i] = '0;
    end
    clear_position();
  endtask

  // Advance the model by one transferred sample and queue any green it causes
  task automatic predict_green(input bgpi_pkg::sample_t s);
    int                w;
    int                h;
    int                x;
    bgpi_pkg::result_t r;
    w = clamp_dim(cfg_width, MAX_WIDTH);
    h = clamp_dim(cfg_height, MAX_HEIGHT);
    // Bypass: every pixel comes straight back, flushes do nothing
    if (!cfg_enable) begin
      if (s.command == bgpi_pkg::CMD_FLUSH) return;
      r.green      = s.pixel;
      r.frame_last = (col_pos + 1 >= w) && (row_pos + 1 >= h);
      expected_green.push_back(r);
      used_items++;
      passed_through++;
      if (r.frame_last) begin
        clear_position();
      end else if (col_pos + 1 >= w) begin
        col_pos = 0;
        row_pos++;
      end else begin
        col_pos++;
      end
      return;
    end
    // Pixel: emit the row above, then shift the column into the stores
    if (s.command == bgpi_pkg::CMD_PIXEL) begin
      if (row_pos >= h || col_pos >= w) return;
      x = col_pos;
      if (row_pos >= 1) begin
        r.green      = cross_green(x, row_pos - 1, w, s.pixel);
        r.frame_last = 1'b0;
        expected_green.push_back(r);
      end
      line_above[x]  = line_center[x];
      line_center[x] = s.pixel;
      used_items++;
      if (x + 1 >= w) begin
        col_pos = 0;
        row_pos++;
      end else begin
        col_pos++;
      end
      return;
    end
    // Flush: drain the last row once every row is in
    if (row_pos < h || drain_pos >= w) return;
    x              = drain_pos;
    r.green        = cross_green(x, h - 1, w, line_center[x]);
    r.frame_last   = (x + 1 >= w);
    line_above[x]  = line_center[x];
    expected_green.push_back(r);
    used_items++;
    drained_greens++;
    if (r.frame_last) clear_position();
    else drain_pos++;
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t ns", what, got, want, $time);
    mismatches++;
  endtask

  // Compare each result transfer with the oldest expected green
  always @(posedge clk) begin : check_results
    bgpi_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (result.frame_last) frame_ends++;
      if (expected_green.size() == 0) begin
        report_mismatch("result with nothing pending, green", result.green, 0);
      end else begin
        want = expected_green.pop_front();
        if (result.green !== want.green)
          report_mismatch("green", result.green, want.green);
        if (result.frame_last !== want.frame_last)
          report_mismatch("frame_last", result.frame_last, want.frame_last);
      end
    end
  end

  // Randomize receiver back-pressure
  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= stall_pct);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || cfg_we || (sample_valid && sample_ready) || (result_valid && result_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transfer in %0d cycles", STALL_LIMIT);
      $display("tb_top failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [FIELD_BITS-1:0] rand_pixel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return FIELD_BITS'($urandom_range(15));
      default: return FIELD_BITS'($urandom);
    endcase
  endfunction

  // Offer one sample after a random gap and hold it until the transfer
  task automatic send_item(input bgpi_pkg::command_t cmd,
                           input logic [FIELD_BITS-1:0] px);
    bgpi_pkg::sample_t item;
    item.command = cmd;
    item.pixel   = px;
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= item;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    transfers_in++;
    predict_green(item);
  endtask

  // Drop valid and hold off until every expected green has come back
  task automatic wait_for_results();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (expected_green.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input bgpi_pkg::cfg_reg_t idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_BITS-1:0];
    @(posedge clk);
    case (idx)
      bgpi_pkg::REG_PATTERN:      cfg_pattern = val[1:0];
      bgpi_pkg::REG_FRAME_WIDTH:  cfg_width   = val[DIM_BITS-1:0];
      bgpi_pkg::REG_FRAME_HEIGHT: cfg_height  = val[DIM_BITS-1:0];
      bgpi_pkg::REG_ENABLE:       cfg_enable  = val[0];
      default:                    ;
    endcase
    clear_position();
  endtask

  task automatic configure(input int pat, input int w, input int h, input int en);
    wait_for_results();
    write_reg(bgpi_pkg::REG_PATTERN, pat);
    write_reg(bgpi_pkg::REG_FRAME_WIDTH, w);
    write_reg(bgpi_pkg::REG_FRAME_HEIGHT, h);
    write_reg(bgpi_pkg::REG_ENABLE, en);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // One frame at the current setting, with stray items and optional early stop
  task automatic run_frame(input bit may_break);
    int w;
    int h;
    int total;
    int cut;
    w     = clamp_dim(cfg_width, MAX_WIDTH);
    h     = clamp_dim(cfg_height, MAX_HEIGHT);
    total = w * h;
    cut   = (may_break && $urandom_range(19) == 0) ? $urandom_range(total - 1) : total;
    for (int i = 0; i < cut; i++) begin
      if (may_break && $urandom_range(29) == 0)
        send_item(bgpi_pkg::CMD_FLUSH, rand_pixel());
      if (may_break && $urandom_range(49) == 0) wait_for_results();
      send_item(bgpi_pkg::CMD_PIXEL, rand_pixel());
    end
    if (cut < total || !cfg_enable) return;
    for (int i = 0; i < w; i++) begin
      if (may_break && $urandom_range(29) == 0)
        send_item(bgpi_pkg::CMD_PIXEL, rand_pixel());
      send_item(bgpi_pkg::CMD_FLUSH, rand_pixel());
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Default geometry is full size: a partial first row and an early flush
  // must give nothing
  task automatic test_reset_state();
    send_item(bgpi_pkg::CMD_PIXEL, 16'h0000);
    send_item(bgpi_pkg::CMD_PIXEL, 16'hFFFF);
    send_item(bgpi_pkg::CMD_FLUSH, 16'hFFFF);
  endtask

  // 3x2 frame: edge clamps, early flush, pixel while draining, drain
  task automatic test_small_frame();
    configure(2, 3, 2, 1);
    send_item(bgpi_pkg::CMD_PIXEL, 16'hFFFF);
    send_item(bgpi_pkg::CMD_PIXEL, 16'h0000);
    send_item(bgpi_pkg::CMD_PIXEL, 16'hFFFF);
    send_item(bgpi_pkg::CMD_FLUSH, 16'h0000);
    send_item(bgpi_pkg::CMD_PIXEL, 16'h0000);
    send_item(bgpi_pkg::CMD_PIXEL, 16'hFFFF);
    send_item(bgpi_pkg::CMD_PIXEL, 16'h1234);
    send_item(bgpi_pkg::CMD_PIXEL, 16'hABCD);
    repeat (3) send_item(bgpi_pkg::CMD_FLUSH, 16'h5A5A);
  endtask

  // Zero geometry clamps to a single pixel: every neighbor is the pixel
  task automatic test_single_pixel();
    configure(1, 0, 0, 1);
    send_item(bgpi_pkg::CMD_PIXEL, 16'h8001);
    send_item(bgpi_pkg::CMD_FLUSH, 16'h0000);
  endtask

  // Bypass: no lag, flushes ignored, frame end on the last raster pixel
  task automatic test_bypass();
    configure(3, 2, 2, 16'h1FFE);
    send_item(bgpi_pkg::CMD_PIXEL, 16'h5555);
    send_item(bgpi_pkg::CMD_FLUSH, 16'hFFFF);
    send_item(bgpi_pkg::CMD_PIXEL, 16'hAAAA);
    send_item(bgpi_pkg::CMD_PIXEL, 16'h7FFF);
    send_item(bgpi_pkg::CMD_PIXEL, 16'h8000);
    send_item(bgpi_pkg::CMD_PIXEL, 16'h0001);
  endtask

  // Out-of-range geometry clamps to the largest frame: run the start of a
  // widest bypass row and of a tallest one-column frame
  task automatic test_max_geometry();
    configure(0, 8191, 8191, 0);
    repeat (EDGE_ITEMS) send_item(bgpi_pkg::CMD_PIXEL, rand_pixel());
    configure(1, 1, 8191, 1);
    repeat (EDGE_ITEMS) send_item(bgpi_pkg::CMD_PIXEL, rand_pixel());
    send_item(bgpi_pkg::CMD_FLUSH, rand_pixel());
  endtask

  // Random settings and frames under one idling mix
  task automatic test_random_frames(input int idle_in, input int stall_out);
    int start;
    int w;
    int h;
    send_idle_pct = idle_in;
    stall_pct     = stall_out;
    start         = used_items;
    while (used_items - start < PHASE_ITEMS) begin
      w = ($urandom_range(9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 48);
      if ($urandom_range(19) == 0) w = 0;
      h = $urandom_range(1, 5);
      if ($urandom_range(19) == 0) h = 0;
      configure($urandom_range(3), w, h, ($urandom_range(9) < 8));
      repeat ($urandom_range(1, 3)) run_frame(1'b1);
    end
  endtask

  initial begin
    reset_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_small_frame();
    test_single_pixel();
    test_bypass();
    test_max_geometry();
    test_random_frames(0, 0);
    test_random_frames(53, 0);
    test_random_frames(0, 53);
    test_random_frames(22, 22);
    wait_for_results();
    $display("Summary: %0d samples transferred, %0d acted on, %0d register settings.",
             transfers_in, used_items, settings_used);
    $display("Summary: %0d greens checked (%0d drained, %0d bypassed), %0d frame ends.",
             results_seen, drained_greens, passed_through, frame_ends);
    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/bgpi_pkg.sv
design/bgpi_line_ram.sv
design/bgpi_out_fifo.sv
design/bayer_green_plane_interpolator_core.sv
tb/sv/tb_top.sv
